>>> rtl/frs_pkg.sv
// Package for the fault remedy escalation supervisor.
// Holds the shared widths, codes and the result record. Depends on nothing.
package frs_pkg;

  localparam int unsigned TIME_W_DEF = 40;
  localparam int unsigned ACT_W      = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [11:0] PAGE_BASE = 12'd60;
  localparam logic [12:0] PAGE_CAP  = 13'd3600;

  typedef enum logic [1:0] {
    EVT_DETECTED = 2'd0,
    EVT_REMEDY   = 2'd1,
    EVT_CLEARED  = 2'd2,
    EVT_OPERATOR = 2'd3
  } evt_kind_e;

  typedef enum logic [1:0] {
    REP_OK          = 2'd0,
    REP_FAILED      = 2'd1,
    REP_SKIP        = 2'd2,
    REP_UNWITNESSED = 2'd3
  } report_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_PERIOD    = 2'd0,
    CFG_REMEDY_BACKOFF = 2'd1,
    CFG_ATTEMPT_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [7:0]       attempt_count;
    logic [1:0]       remedy_report;
    logic [31:0]      cleared_total;
    logic [15:0]      page_number;
    logic [11:0]      next_gap_secs;
    logic [ACT_W-1:0] active_for_secs;
    logic             last_in_run;
  } res_t;

endpackage

>>> rtl/frs_if.sv
// Channel interfaces of the fault remedy escalation supervisor: tick in,
// event out and register write. Depends on frs_pkg.
interface frs_in_if import frs_pkg::*; #(
  parameter int unsigned TW = TIME_W_DEF
) ();
  logic          valid;
  logic          ready;
  logic [TW-1:0] now_secs;
  logic          detected;
  logic          gone_before;
  logic [1:0]    remedy_code;
  logic          gone_after;

  modport source (output valid, now_secs, detected, gone_before, remedy_code, gone_after,
                  input ready);
  modport sink   (input valid, now_secs, detected, gone_before, remedy_code, gone_after,
                  output ready);
endinterface

interface frs_out_if import frs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       event_kind;
  logic [7:0]       attempt_count;
  logic [1:0]       remedy_report;
  logic [31:0]      cleared_total;
  logic [15:0]      page_number;
  logic [11:0]      next_gap_secs;
  logic [ACT_W-1:0] active_for_secs;
  logic             last_in_run;

  modport source (output valid, event_kind, attempt_count, remedy_report, cleared_total,
                  page_number, next_gap_secs, active_for_secs, last_in_run,
                  input ready);
  modport sink   (input valid, event_kind, attempt_count, remedy_report, cleared_total,
                  page_number, next_gap_secs, active_for_secs, last_in_run,
                  output ready);
endinterface

interface frs_cfg_if import frs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

>>> rtl/fault_remedy_escalation_supervisor_unit.sv
// Top level of the fault remedy escalation supervisor.
// Depends on frs_pkg and the channel interfaces in frs_if.sv.
//
//   channel  modport  direction  carries
//   -------  -------  ---------  -----------------------------------------------
//   in_i     sink     in         one tick: time, detect, witness, remedy answers
//   res_o    source   out        one event per transfer, last_in_run ends a tick
//   cfg_i    sink     in         register write: index and data, always ready
//
// A tick is taken into an input register, evaluated against the episode state
// in one pass of logic and its zero to three events are pushed into a four-entry
// event queue at the end of that cycle, so its first event is offered from the
// queue register after the input register; a queue too full to take the run holds
// it back. The queue drains one event a cycle while the event sink is ready. The
// input register advances while at most one event waits after this cycle's
// transfer; a stalled event sink holds it. rst_ni clears control state and loads register defaults.
module fault_remedy_escalation_supervisor_unit import frs_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  frs_in_if.sink    in_i,
  frs_out_if.source res_o,
  frs_cfg_if.sink   cfg_i
);

  localparam int unsigned TW = TIME_WIDTH;

  // Episode state; a stamp of zero means never.
  typedef struct packed {
    logic          active;
    logic [TW-1:0] fdt;       // first detection
    logic [TW-1:0] lpt;       // last poll
    logic [TW-1:0] lrt;       // last remedy
    logic [TW-1:0] lpgt;      // last page
    logic [7:0]    attempts;
    logic [1:0]    report;
    logic [11:0]   gap;
    logic [15:0]   pages;
  } epi_t;

  typedef struct packed {
    logic [TW-1:0] now_secs;
    logic          detected;
    logic          gone_before;
    logic [1:0]    remedy_code;
    logic          gone_after;
  } tick_t;

  localparam epi_t EPI_WIPE = '{
    active:   1'b0,
    fdt:      '0,
    lpt:      '0,
    lrt:      '0,
    lpgt:     '0,
    attempts: 8'd0,
    report:   REP_SKIP,
    gap:      PAGE_BASE,
    pages:    16'd0
  };

  function automatic logic elapsed(input logic [TW-1:0] now, input logic [TW-1:0] then,
                                   input logic [TW-1:0] gap);
    logic [TW-1:0] diff;
    diff = now - then;
    return (now >= then) && (diff >= gap);
  endfunction

  function automatic res_t mk_res(input evt_kind_e kind, input epi_t e,
                                  input logic [31:0] cc, input logic [ACT_W-1:0] act);
    res_t r;
    r.event_kind      = kind;
    r.attempt_count   = e.attempts;
    r.remedy_report   = e.report;
    r.cleared_total   = cc;
    r.page_number     = e.pages;
    r.next_gap_secs   = e.gap;
    r.active_for_secs = act;
    r.last_in_run     = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] poll_q, backoff_q;
  logic [7:0]  limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q    <= 16'd1;
      backoff_q <= 16'd0;
      limit_q   <= 8'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        CFG_POLL_PERIOD:    poll_q    <= cfg_i.wdata;
        CFG_REMEDY_BACKOFF: backoff_q <= cfg_i.wdata;
        CFG_ATTEMPT_LIMIT:  limit_q   <= cfg_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  // Zero in either register acts as one.
  logic [15:0] poll_eff;
  logic [7:0]  limit_eff;
  assign poll_eff  = (poll_q == 16'd0) ? 16'd1 : poll_q;
  assign limit_eff = (limit_q == 8'd0) ? 8'd1 : limit_q;

  // ---------------------------------------------------------------------------
  // Input register and event queue handshake
  // ---------------------------------------------------------------------------
  logic        inq_vld_q;
  tick_t       inq_q;
  logic [2:0]  cnt_q, cnt_d, cnt_after_pop;
  logic [1:0]  wr_q, rd_q;
  logic        pop, adv, in_xfer;
  logic [1:0]  n_res;
  res_t        res_a [3];
  res_t        fifo_q [4];

  assign pop           = res_o.valid && res_o.ready;
  assign cnt_after_pop = cnt_q - {2'b00, pop};
  // Advance only with room for a full run of three events.
  assign adv           = inq_vld_q && (cnt_after_pop <= 3'd1);
  assign in_i.ready    = !inq_vld_q || adv;
  assign in_xfer       = in_i.valid && in_i.ready;
  assign cnt_d         = cnt_after_pop + (adv ? {1'b0, n_res} : 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      inq_q.now_secs    <= in_i.now_secs;
      inq_q.detected    <= in_i.detected;
      inq_q.gone_before <= in_i.gone_before;
      inq_q.remedy_code <= in_i.remedy_code;
      inq_q.gone_after  <= in_i.gone_after;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick evaluation
  // ---------------------------------------------------------------------------
  epi_t          epi_q, epi_d;
  logic [31:0]   cc_q, cc_d;
  logic [TW-1:0] now, fdt_cur, act_diff;
  logic [ACT_W-1:0] act;
  logic          skip, rem_go, done;
  logic [1:0]    rep;
  logic [12:0]   gap2;

  assign now      = inq_q.now_secs;
  // First detection stamps now, so the age reads zero on that tick.
  assign fdt_cur  = epi_q.active ? epi_q.fdt : now;
  assign act_diff = (now >= fdt_cur) ? (now - fdt_cur) : '0;
  assign act      = ACT_W'(act_diff);
  assign gap2     = {epi_q.gap, 1'b0};

  always_comb begin
    epi_d  = epi_q;
    cc_d   = cc_q;
    n_res  = 2'd0;
    rem_go = 1'b0;
    done   = 1'b0;
    rep    = REP_FAILED;
    for (int i = 0; i < 3; i++) begin
      res_a[i] = '0;
    end

    // Idle and inside the poll period: drop the tick.
    skip = !epi_q.active && (epi_q.lpt != '0) &&
           !elapsed(now, epi_q.lpt, TW'(poll_eff));

    if (!skip) begin
      if (!epi_q.active) begin
        epi_d.lpt = now;
      end
      if (!inq_q.detected) begin
        if (epi_q.active) begin
          if (inq_q.gone_before) begin
            cc_d         = cc_q + 32'd1;
            res_a[n_res] = mk_res(EVT_CLEARED, epi_d, cc_d, act);
            n_res        = n_res + 2'd1;
            epi_d        = EPI_WIPE;
          end
        end else begin
          epi_d     = EPI_WIPE;
          epi_d.lpt = now;
        end
      end else begin
        if (!epi_q.active) begin
          epi_d.active = 1'b1;
          epi_d.fdt    = now;
          res_a[n_res] = mk_res(EVT_DETECTED, epi_d, cc_q, act);
          n_res        = n_res + 2'd1;
        end
        if (inq_q.gone_before) begin
          cc_d         = cc_q + 32'd1;
          res_a[n_res] = mk_res(EVT_CLEARED, epi_d, cc_d, act);
          n_res        = n_res + 2'd1;
          epi_d        = EPI_WIPE;
        end else begin
          rem_go = (epi_d.attempts < limit_eff) &&
                   ((epi_d.lrt == '0) || elapsed(now, epi_d.lrt, TW'(backoff_q)));
          if (rem_go) begin
            // Code three reads as failed; an unwitnessed ok is flagged.
            rep = (inq_q.remedy_code == REP_UNWITNESSED) ? REP_FAILED : inq_q.remedy_code;
            if ((rep == REP_OK) && !inq_q.gone_after) begin
              rep = REP_UNWITNESSED;
            end
            epi_d.attempts = epi_d.attempts + 8'd1;
            epi_d.lrt      = now;
            epi_d.report   = rep;
            res_a[n_res]   = mk_res(EVT_REMEDY, epi_d, cc_q, act);
            n_res          = n_res + 2'd1;
            if (inq_q.gone_after) begin
              cc_d         = cc_q + 32'd1;
              res_a[n_res] = mk_res(EVT_CLEARED, epi_d, cc_d, act);
              n_res        = n_res + 2'd1;
              epi_d        = EPI_WIPE;
              done         = 1'b1;
            end
          end
          if (!done && (epi_d.attempts >= limit_eff)) begin
            if ((epi_q.lpgt == '0) || elapsed(now, epi_q.lpgt, TW'(epi_q.gap))) begin
              // Double the gap after the first page, capped.
              if (epi_q.lpgt != '0) begin
                epi_d.gap = (gap2 > PAGE_CAP) ? PAGE_CAP[11:0] : gap2[11:0];
              end
              epi_d.lpgt = now;
              if (epi_q.pages != 16'hFFFF) begin
                epi_d.pages = epi_q.pages + 16'd1;
              end
              res_a[n_res] = mk_res(EVT_OPERATOR, epi_d, cc_q, act);
              n_res        = n_res + 2'd1;
            end
          end
        end
      end
    end

    if (n_res != 2'd0) begin
      res_a[n_res - 2'd1].last_in_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epi_q <= EPI_WIPE;
      cc_q  <= 32'd0;
    end else if (adv) begin
      epi_q <= epi_d;
      cc_q  <= cc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Event queue: push the tick's run, drain one event per transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (adv) begin
        wr_q <= wr_q + n_res;
      end
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (adv && (2'(i) < n_res)) begin
        fifo_q[wr_q + 2'(i)] <= res_a[i];
      end
    end
  end

  assign res_o.valid           = (cnt_q != 3'd0);
  assign res_o.event_kind      = fifo_q[rd_q].event_kind;
  assign res_o.attempt_count   = fifo_q[rd_q].attempt_count;
  assign res_o.remedy_report   = fifo_q[rd_q].remedy_report;
  assign res_o.cleared_total   = fifo_q[rd_q].cleared_total;
  assign res_o.page_number     = fifo_q[rd_q].page_number;
  assign res_o.next_gap_secs   = fifo_q[rd_q].next_gap_secs;
  assign res_o.active_for_secs = fifo_q[rd_q].active_for_secs;
  assign res_o.last_in_run     = fifo_q[rd_q].last_in_run;

endmodule
